### sv/tdpt_pkg.sv
// Package for the trial-division prime test block.
// Holds shared constants and the request/response structs of the remainder unit.
// No dependencies.
`default_nettype none

package tdpt_pkg;

    // Default width of the candidate value.
    localparam int DEFAULT_VALUE_WIDTH = 31;

    // The only even prime, and the first odd trial divisor.
    localparam int EVEN_PRIME    = 2;
    localparam int FIRST_DIVISOR = 3;
    localparam int DIVISOR_STEP  = 2;

    // Start request to the remainder unit.
    typedef struct packed {
        logic start;
    } rem_req_t;

    // Completion report from the remainder unit.
    typedef struct packed {
        logic done;
        logic zero;
    } rem_rsp_t;

endpackage

`default_nettype wire

### sv/tdpt_if.sv
// Handshake channels of the trial-division prime test block.
// One interface for the candidate beat and one for the result beat; depends on tdpt_pkg.
`default_nettype none

interface tdpt_query_if
    import tdpt_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_answer_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

`default_nettype wire

### sv/tdpt_rem_unit.sv
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on tdpt_pkg for the request and response structs.
`default_nettype none

module tdpt_rem_unit
    import tdpt_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire rem_req_t               req,
    input  wire logic [VALUE_WIDTH-1:0] dividend,
    input  wire logic [VALUE_WIDTH-1:0] divisor,
    output rem_rsp_t                    rsp
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] dvd_reg, dvd_next;
    logic [VALUE_WIDTH-1:0] dsr_reg, dsr_next;

    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH+1:0] diff;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign trial = {rem_reg, dvd_reg[VALUE_WIDTH-1]};
    assign diff  = {1'b0, trial} - {2'b00, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VALUE_WIDTH);
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it fits the value width.
            if (diff[VALUE_WIDTH+1])
            begin
                rem_next = trial[VALUE_WIDTH-1:0];
            end
            else
            begin
                rem_next = diff[VALUE_WIDTH-1:0];
            end
            dvd_next = {dvd_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.zero = (rem_reg == '0);

endmodule

`default_nettype wire

### sv/trial_division_prime_test_top.sv
// Trial-division prime test. Values below 3 and even values are decided without
// trial division; other values try odd divisors, up to sqrt(candidate)/2 of them,
// each one through the bit-serial remainder unit. One candidate at a time; a new
// beat is taken while the previous result waits. Asynchronous active-low reset
// empties the block.
//
// Depends on tdpt_pkg, tdpt_if and tdpt_rem_unit.
`default_nettype none

module trial_division_prime_test_top
    import tdpt_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tdpt_query_if.sink  query,
    tdpt_answer_if.source answer
);

    // The candidate is held in n_reg. Odd divisors d = 3, 5, 7, ... are tried
    // while d*d <= n. The square is tracked incrementally as
    // (d+2)^2 = d^2 + 4d + 4, so no multiplier is needed. For every divisor the
    // shared remainder unit computes n mod d; a zero remainder stops the search
    // with a composite verdict.

    localparam int SQ_W = VALUE_WIDTH + 2;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic                   verdict_reg, verdict_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_prime_reg, out_prime_next;

    logic     in_beat;
    logic     out_free;
    rem_req_t rem_req;
    rem_rsp_t rem_rsp;

    // The result register is free when empty or when its beat leaves this cycle.
    assign out_free = !out_valid_reg || answer.ready;
    assign in_beat  = query.valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        verdict_next   = verdict_reg;
        out_valid_next = out_valid_reg;
        out_prime_next = out_prime_reg;
        rem_req.start  = 1'b0;

        if (out_valid_reg && answer.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    n_next  = query.candidate;
                    d_next  = VALUE_WIDTH'(FIRST_DIVISOR);
                    sq_next = SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
                    if (query.candidate < VALUE_WIDTH'(FIRST_DIVISOR))
                    begin
                        // Zero and one are not prime; two is.
                        verdict_next = (query.candidate == VALUE_WIDTH'(EVEN_PRIME));
                        state_next   = ST_DONE;
                    end
                    else if (!query.candidate[0])
                    begin
                        verdict_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (sq_reg > {2'b00, n_reg})
                begin
                    // No divisor up to the square root divides the value.
                    verdict_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    rem_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rem_rsp.done)
                begin
                    if (rem_rsp.zero)
                    begin
                        verdict_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        sq_next    = sq_reg + (SQ_W'(d_reg) << 2) + SQ_W'(4);
                        d_next     = d_reg + VALUE_WIDTH'(DIVISOR_STEP);
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_prime_next = verdict_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        verdict_reg   <= verdict_next;
        out_prime_reg <= out_prime_next;
    end

    tdpt_rem_unit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (rem_req),
        .dividend (n_reg),
        .divisor  (d_reg),
        .rsp      (rem_rsp)
    );

    assign query.ready     = (state_reg == ST_IDLE);
    assign answer.valid    = out_valid_reg;
    assign answer.is_prime = out_prime_reg;

endmodule

`default_nettype wire

### verif/trial_division_prime_test_top_test.sv
// Self-checking testbench for trial_division_prime_test_top: candidates go in over the
// query channel, and each primality answer is checked against a software trial division.
// Depends on tdpt_pkg, tdpt_if and the block itself.
`timescale 1ns / 100ps

module trial_division_prime_test_top_test
    import tdpt_pkg::*;
();

    localparam int VALUE_WIDTH   = DEFAULT_VALUE_WIDTH;
    localparam int RANDOM_ITEMS  = 80;
    // The slowest run is dominated by the one 31-bit prime; everything else
    // together stays well below that. Take it several times over.
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int DRAIN_CYCLES  = 50;

    typedef logic [VALUE_WIDTH-1:0] value_t;

    // One outstanding answer: the candidate that caused it and the flag it must carry.
    typedef struct {
        value_t candidate;
        bit     is_prime;
    } answer_t;

    logic clk;
    logic rst_n;

    tdpt_query_if #(.VALUE_WIDTH(VALUE_WIDTH)) query_ch ();
    tdpt_answer_if answer_ch ();

    trial_division_prime_test_top #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .answer (answer_ch)
    );

    value_t  candidates_to_send[$];
    answer_t answers_due[$];
    int      total_candidates;
    int      sent_count;
    int      error_count;
    int      cycle_count;

    // Clock with a 4 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Trial division over odd divisors, stopping as soon as the divisor squared
    // would pass the value. The bound is written as a division so that it
    // cannot overflow.
    function automatic bit trial_divide(value_t n);
        longint unsigned v;
        longint unsigned d;
        v = n;
        if (v <= EVEN_PRIME)
            return v == EVEN_PRIME;
        if (v % 2 == 0)
            return 1'b0;
        for (d = FIRST_DIVISOR; d <= v / d; d += DIVISOR_STEP)
        begin
            if (v % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // The run goes through three idling phases, chosen by how far the stimulus
    // has got: a slow receiver first, then a slow sender, then full speed.
    function automatic int idle_phase();
        if (sent_count * 3 < total_candidates)
            return 0;
        if (sent_count * 3 < total_candidates * 2)
            return 1;
        return 2;
    endfunction

    function automatic int sender_idle_pct();
        case (idle_phase())
            0: return 27;
            1: return 81;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (idle_phase())
            0: return 81;
            1: return 27;
            default: return 0;
        endcase
    endfunction

    // Random candidates. The cost of the block grows with the square root of the
    // value for primes, so most candidates are small. The large ones are built to
    // leave the divisor loop early: either even, or a random multiple of a small
    // odd factor. They still reach every bit of the field, the top one included.
    function automatic value_t random_candidate();
        int unsigned pick;
        int unsigned factor;
        value_t      v;
        pick = $urandom_range(99);
        if (pick < 70)
            return value_t'($urandom_range(4095));
        if (pick < 80)
            return value_t'($urandom_range(65535));
        if (pick < 90)
        begin
            v = value_t'($urandom());
            v[0] = 1'b0;
            return v;
        end
        factor = FIRST_DIVISOR + DIVISOR_STEP * $urandom_range(2);
        return value_t'(factor * $urandom_range(((1 << VALUE_WIDTH) - 1) / factor));
    endfunction

    // Stimulus, the final verdict and the reset sequence.
    initial
    begin
        rst_n = 1'b0;
        query_ch.valid = 1'b0;
        query_ch.candidate = '0;
        answer_ch.ready = 1'b0;
        sent_count = 0;
        error_count = 0;

        // Directed candidates: zero, one and two, the first odd values, even
        // values, squares of primes where the last divisor tried equals the
        // square root, the largest 16-bit prime, alternating bit patterns, and
        // both ends of the field. The all-ones value is itself prime and is the
        // slowest candidate the block can get.
        candidates_to_send = '{
            value_t'(0), value_t'(1), value_t'(2), value_t'(3), value_t'(4),
            value_t'(5), value_t'(9), value_t'(15), value_t'(25), value_t'(49),
            value_t'(97), value_t'(121), value_t'(63001), value_t'(65521),
            value_t'(65535), value_t'(1073741824), value_t'(715827882),
            value_t'(1431655765), value_t'(2147483645), value_t'(2147483646),
            value_t'(2147483647)
        };
        repeat (RANDOM_ITEMS)
            candidates_to_send.push_back(random_candidate());
        total_candidates = candidates_to_send.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every candidate to go out and every answer to come back, then
        // let the clock run on so that the block can show any stray answer.
        while (candidates_to_send.size() != 0 || query_ch.valid || answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Candidate driver. A new beat is offered only when the previous one has been
    // taken or none was up, so valid is assigned at most once per edge and a
    // candidate never changes while it waits. The expected answer is worked out
    // when the beat is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_ch.valid <= 1'b0;
            query_ch.candidate <= '0;
        end
        else
        begin
            if (query_ch.valid && query_ch.ready)
            begin
                answers_due.push_back('{candidate: query_ch.candidate,
                                        is_prime: trial_divide(query_ch.candidate)});
                sent_count++;
            end
            if (!query_ch.valid || query_ch.ready)
            begin
                if (candidates_to_send.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct())
                begin
                    query_ch.valid <= 1'b1;
                    query_ch.candidate <= candidates_to_send.pop_front();
                end
                else
                begin
                    query_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Answer monitor. Every accepted answer beat is matched with the oldest
    // candidate still waiting; ready is toggled at random to stall the block.
    always @(posedge clk or negedge rst_n)
    begin
        answer_t due;
        if (!rst_n)
        begin
            answer_ch.ready <= 1'b0;
        end
        else
        begin
            if (answer_ch.valid && answer_ch.ready)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("answer beat with no candidate outstanding: is_prime=%0b",
                           answer_ch.is_prime);
                    error_count++;
                end
                else
                begin
                    due = answers_due.pop_front();
                    if (answer_ch.is_prime !== due.is_prime)
                    begin
                        $error("is_prime for candidate %0d: expected %0b, actual %0b",
                               due.candidate, due.is_prime, answer_ch.is_prime);
                        error_count++;
                    end
                end
            end
            answer_ch.ready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // Watchdog against a block that hangs.
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
